[design/pmlp_pkg.sv]
// ----------------------------------------------------------------------------
// pmlp_pkg
// Shared types and constants for the packet match latency probe.
// ----------------------------------------------------------------------------
package pmlp_pkg;

   localparam int PAT_BYTES_MAX = 8;
   localparam int PAT_WIDTH     = 64;
   localparam int ADDR_WIDTH    = 6;
   localparam int DATA_WIDTH    = 64;

   typedef enum logic [2:0] {
      REG_MID_IP      = 3'd0,
      REG_MID_PORT    = 3'd1,
      REG_OUT_IP      = 3'd2,
      REG_OUT_PORT    = 3'd3,
      REG_IN_LEN      = 3'd4,
      REG_OUT_LEN     = 3'd5,
      REG_PATTERN     = 3'd6,
      REG_PATTERN_LEN = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      CLS_IGNORED  = 2'd0,
      CLS_PARSED   = 2'd1,
      CLS_INBOUND  = 2'd2,
      CLS_OUTBOUND = 2'd3
   } frame_class_type;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   // frame digest handed from the parser to the decision stage
   typedef struct packed {
      logic        ok;
      logic [31:0] dst_ip;
      logic [15:0] dst_port;
      logic [15:0] pay_len;
      logic        content;
      logic [63:0] time_us;
      logic [31:0] frame_num;
   } summary_type;

   typedef struct packed {
      frame_class_type frame_class;
      logic            port_learned;
      logic [15:0]     learned_port;
      logic            latency_valid;
      logic [63:0]     latency_us;
      logic [31:0]     in_frame_index;
      logic [31:0]     out_frame_index;
   } result_type;

endpackage

[design/pmlp_parser.sv]
// ----------------------------------------------------------------------------
// pmlp_parser
// Byte-wise Ethernet/IPv4/UDP/TCP header parser and payload pattern scanner.
// ----------------------------------------------------------------------------
module pmlp_parser #(
   parameter int MAX_PATTERN = 8,
   parameter int TIME_WIDTH  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 byte_valid,
   input  logic [7:0]           data_byte,
   input  logic                 frame_start,
   input  logic                 frame_end,
   input  logic                 truncated,
   input  logic [TIME_WIDTH-1:0] timestamp,
   input  logic [3:0]           eff_plen,
   input  logic [63:0]          pattern,
   output logic                 sum_valid,
   output pmlp_pkg::summary_type sum
);

   localparam int WIN_BYTES = (MAX_PATTERN < pmlp_pkg::PAT_BYTES_MAX) ?
                              MAX_PATTERN : pmlp_pkg::PAT_BYTES_MAX;
   localparam int WIN_W = 8 * WIN_BYTES;

   logic                  open_ff, open_in;
   logic                  bad_ff, bad_in;
   logic                  pay_ff, pay_in;
   logic [15:0]           off_ff, off_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic [15:0]           etype_ff, etype_in;
   logic [7:0]            vi_ff, vi_in;
   logic [7:0]            proto_ff, proto_in;
   logic [15:0]           totlen_ff, totlen_in;
   logic [31:0]           dip_ff, dip_in;
   logic [15:0]           dport_ff, dport_in;
   logic [15:0]           udplen_ff, udplen_in;
   logic [3:0]            doff_ff, doff_in;
   logic [15:0]           rem_ff, rem_in;
   logic [15:0]           tot_ff, tot_in;
   logic [WIN_W-1:0]      win_ff, win_in;
   logic                  cf_ff, cf_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [31:0]           count_ff, count_in;
   logic                  sum_valid_ff, sum_valid_in;
   pmlp_pkg::summary_type sum_ff, sum_in;

   logic                  go;
   logic                  have;
   logic [15:0]           l4;
   logic [15:0]           pstart;
   logic signed [17:0]    plen;
   logic                  win_hit;
   logic                  step;

   assign step = advance && byte_valid;

   always_comb begin
      open_in   = open_ff;
      bad_in    = bad_ff;
      pay_in    = pay_ff;
      off_in    = off_ff;
      time_in   = time_ff;
      etype_in  = etype_ff;
      vi_in     = vi_ff;
      proto_in  = proto_ff;
      totlen_in = totlen_ff;
      dip_in    = dip_ff;
      dport_in  = dport_ff;
      udplen_in = udplen_ff;
      doff_in   = doff_ff;
      rem_in    = rem_ff;
      tot_in    = tot_ff;
      win_in    = win_ff;
      cf_in     = cf_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      go        = 1'b0;
      have      = 1'b0;
      l4        = '0;
      pstart    = '0;
      plen      = '0;
      win_hit   = 1'b0;
      sum_valid_in = 1'b0;
      sum_in    = sum_ff;

      if (frame_start) begin
         count_in  = count_ff + 32'd1;
         open_in   = 1'b1;
         bad_in    = 1'b0;
         pay_in    = 1'b0;
         off_in    = '0;
         time_in   = timestamp;
         etype_in  = '0;
         vi_in     = '0;
         proto_in  = '0;
         totlen_in = '0;
         dip_in    = '0;
         dport_in  = '0;
         udplen_in = '0;
         doff_in   = '0;
         rem_in    = '0;
         tot_in    = '0;
         win_in    = '0;
         cf_in     = 1'b0;
         cnt_in    = '0;
      end

      if (open_in) begin
         if (truncated) bad_in = 1'b1;
         go = !bad_in;
         if (go) begin
            if (off_in == 16'd12) etype_in[15:8] = data_byte;
            if (off_in == 16'd13) etype_in[7:0]  = data_byte;
            if (off_in == 16'd14) vi_in          = data_byte;
            if (off_in == 16'd16) totlen_in[15:8] = data_byte;
            if (off_in == 16'd17) totlen_in[7:0]  = data_byte;
            if (off_in == 16'd23) proto_in       = data_byte;
            if (off_in == 16'd30) dip_in[31:24]  = data_byte;
            if (off_in == 16'd31) dip_in[23:16]  = data_byte;
            if (off_in == 16'd32) dip_in[15:8]   = data_byte;
            if (off_in == 16'd33) dip_in[7:0]    = data_byte;
            if (off_in == 16'd14 && (etype_in != pmlp_pkg::ETYPE_IPV4 ||
                vi_in[7:4] != 4'd4 || vi_in[3:0] < 4'd5)) begin
               bad_in = 1'b1;
               go = 1'b0;
            end
            if (off_in == 16'd23 && proto_in != pmlp_pkg::PROTO_TCP &&
                proto_in != pmlp_pkg::PROTO_UDP) begin
               bad_in = 1'b1;
               go = 1'b0;
            end
            if (off_in <= 16'd14) go = 1'b0;
         end
         if (go) begin
            l4 = 16'd14 + {10'd0, vi_in[3:0], 2'b00};
            if (off_in == l4 + 16'd2)  dport_in[15:8]  = data_byte;
            if (off_in == l4 + 16'd3)  dport_in[7:0]   = data_byte;
            if (off_in == l4 + 16'd4)  udplen_in[15:8] = data_byte;
            if (off_in == l4 + 16'd5)  udplen_in[7:0]  = data_byte;
            if (off_in == l4 + 16'd12) doff_in         = data_byte[7:4];
            if (!pay_in) begin
               if (proto_in == pmlp_pkg::PROTO_UDP) begin
                  have   = 1'b1;
                  pstart = l4 + 16'd8;
                  plen   = $signed({2'b00, udplen_in}) - 18'sd8;
               end else if (off_in > l4 + 16'd12) begin
                  if (doff_in < 4'd5) begin
                     bad_in = 1'b1;
                     go = 1'b0;
                  end else begin
                     have   = 1'b1;
                     pstart = l4 + {10'd0, doff_in, 2'b00};
                     plen   = $signed({2'b00, totlen_in}) -
                              $signed({11'd0, ({1'b0, vi_in[3:0]} + {1'b0, doff_in}), 2'b00});
                  end
               end
               if (go && have && off_in == pstart) begin
                  if (plen <= 18'sd0) begin
                     bad_in = 1'b1;
                     go = 1'b0;
                  end else begin
                     pay_in = 1'b1;
                     tot_in = plen[15:0];
                     rem_in = plen[15:0];
                  end
               end
            end
            if (go && pay_in && rem_in != 16'd0) begin
               if (WIN_BYTES > 1) win_in = {win_ff[WIN_W-9:0], data_byte};
               else win_in = data_byte;
               rem_in = rem_in - 16'd1;
               if (cnt_in != 4'hF) cnt_in = cnt_in + 4'd1;
               // compare only the newest eff_plen bytes
               win_hit = 1'b1;
               for (int i = 0; i < WIN_BYTES; i++) begin
                  if (i < int'(eff_plen) && win_in[8*i +: 8] != pattern[8*i +: 8])
                     win_hit = 1'b0;
               end
               if (eff_plen != 4'd0 && cnt_in >= eff_plen && win_hit) cf_in = 1'b1;
            end
         end
         if (off_in != 16'hFFFF) off_in = off_in + 16'd1;
         if (frame_end) begin
            open_in          = 1'b0;
            sum_valid_in     = 1'b1;
            sum_in.ok        = !bad_in && pay_in && rem_in == 16'd0;
            sum_in.dst_ip    = dip_in;
            sum_in.dst_port  = dport_in;
            sum_in.pay_len   = tot_in;
            sum_in.content   = cf_in;
            sum_in.time_us   = 64'(time_in);
            sum_in.frame_num = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         bad_ff       <= 1'b0;
         pay_ff       <= 1'b0;
         off_ff       <= '0;
         time_ff      <= '0;
         etype_ff     <= '0;
         vi_ff        <= '0;
         proto_ff     <= '0;
         totlen_ff    <= '0;
         dip_ff       <= '0;
         dport_ff     <= '0;
         udplen_ff    <= '0;
         doff_ff      <= '0;
         rem_ff       <= '0;
         tot_ff       <= '0;
         win_ff       <= '0;
         cf_ff        <= 1'b0;
         cnt_ff       <= '0;
         count_ff     <= '0;
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= step && sum_valid_in;
         if (step) begin
            open_ff   <= open_in;
            bad_ff    <= bad_in;
            pay_ff    <= pay_in;
            off_ff    <= off_in;
            time_ff   <= time_in;
            etype_ff  <= etype_in;
            vi_ff     <= vi_in;
            proto_ff  <= proto_in;
            totlen_ff <= totlen_in;
            dip_ff    <= dip_in;
            dport_ff  <= dport_in;
            udplen_ff <= udplen_in;
            doff_ff   <= doff_in;
            rem_ff    <= rem_in;
            tot_ff    <= tot_in;
            win_ff    <= win_in;
            cf_ff     <= cf_in;
            cnt_ff    <= cnt_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) sum_ff <= sum_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

[design/pmlp_decide.sv]
// ----------------------------------------------------------------------------
// pmlp_decide
// Classifies parsed frames, learns the outbound port and pairs latencies.
// ----------------------------------------------------------------------------
module pmlp_decide #(
   parameter int TIME_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  sum_valid,
   input  pmlp_pkg::summary_type sum,
   input  logic [31:0]           mid_ip,
   input  logic [15:0]           mid_port,
   input  logic [31:0]           out_ip,
   input  logic [15:0]           out_port,
   input  logic [15:0]           in_len,
   input  logic [15:0]           out_len,
   input  logic [3:0]            eff_plen,
   input  logic                  port_reload,
   output pmlp_pkg::result_type  result
);

   logic                  seen_ff, seen_in;
   logic                  known_ff, known_in;
   logic [15:0]           lport_ff, lport_in;
   logic                  pend_ff, pend_in;
   logic [TIME_WIDTH-1:0] ptime_ff, ptime_in;
   logic [31:0]           pframe_ff, pframe_in;
   logic                  c_ok, outlen_ok, inlen_ok;
   logic [TIME_WIDTH-1:0] diff;

   always_comb begin
      seen_in   = seen_ff;
      known_in  = known_ff;
      lport_in  = lport_ff;
      pend_in   = pend_ff;
      ptime_in  = ptime_ff;
      pframe_in = pframe_ff;
      c_ok      = eff_plen == 4'd0 || sum.content;
      outlen_ok = out_len == 16'd0 || out_len == sum.pay_len;
      inlen_ok  = in_len == 16'd0 || in_len == sum.pay_len;
      diff      = sum.time_us[TIME_WIDTH-1:0] - ptime_ff;
      result                 = '0;
      result.frame_class     = pmlp_pkg::CLS_IGNORED;
      result.out_frame_index = sum.frame_num;
      if (sum.ok) begin
         if (seen_ff && !known_ff && outlen_ok && sum.dst_ip == out_ip && c_ok) begin
            lport_in = sum.dst_port;
            known_in = 1'b1;
            result.port_learned = 1'b1;
         end
         if (sum.dst_ip == mid_ip && sum.dst_port == mid_port && inlen_ok && c_ok) begin
            result.frame_class = pmlp_pkg::CLS_INBOUND;
            pend_in   = 1'b1;
            ptime_in  = sum.time_us[TIME_WIDTH-1:0];
            pframe_in = sum.frame_num;
            if (!seen_ff && !known_in) seen_in = 1'b1;
         end else if (known_in && sum.dst_ip == out_ip && sum.dst_port == lport_in &&
                      outlen_ok && c_ok) begin
            result.frame_class = pmlp_pkg::CLS_OUTBOUND;
            if (pend_ff) begin
               result.latency_valid  = 1'b1;
               result.latency_us     = 64'(diff);
               result.in_frame_index = pframe_ff;
               pend_in = 1'b0;
            end
         end else begin
            result.frame_class = pmlp_pkg::CLS_PARSED;
         end
      end
      result.learned_port = known_in ? lport_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= 1'b0;
         known_ff  <= 1'b0;
         lport_ff  <= '0;
         pend_ff   <= 1'b0;
         ptime_ff  <= '0;
         pframe_ff <= '0;
      end else if (port_reload) begin
         seen_ff  <= out_port != 16'd0;
         known_ff <= out_port != 16'd0;
         lport_ff <= out_port;
      end else if (advance && sum_valid) begin
         seen_ff   <= seen_in;
         known_ff  <= known_in;
         lport_ff  <= lport_in;
         pend_ff   <= pend_in;
         ptime_ff  <= ptime_in;
         pframe_ff <= pframe_in;
      end
   end

endmodule

[design/packet_match_latency_probe.sv]
// ----------------------------------------------------------------------------
// packet_match_latency_probe
// Parses captured frames byte by byte and reports request/response latency.
// ----------------------------------------------------------------------------
//  channel   | ports          | moves
//  ----------+----------------+-----------------------------------------
//  request   | req_*          | one frame byte with start/end flags
//  response  | rsp_*          | one result per completed frame
//  config    | psel..pready   | APB register access, 8 regs at 8*i
//
// one byte per cycle while no response is held; a result passes the input
// register, parser and decision register after its frame_end byte is taken.
// reset is synchronous and loads the register defaults; no clearing pass.
// all stages move together: a held response stalls intake via req_ready.
module packet_match_latency_probe #(
   parameter int MAX_PATTERN = 8,
   parameter int TIME_WIDTH  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   input  logic        req_frame_end,
   input  logic [63:0] req_timestamp_us,
   input  logic        req_truncated,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_class,
   output logic        rsp_port_learned,
   output logic [15:0] rsp_learned_port,
   output logic        rsp_latency_valid,
   output logic [63:0] rsp_latency_us,
   output logic [31:0] rsp_in_frame_index,
   output logic [31:0] rsp_out_frame_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [pmlp_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [pmlp_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [pmlp_pkg::DATA_WIDTH-1:0] prdata,
   output logic        pready
);

   localparam int CLAMP = (MAX_PATTERN < pmlp_pkg::PAT_BYTES_MAX) ?
                          MAX_PATTERN : pmlp_pkg::PAT_BYTES_MAX;

   logic [31:0] mid_ip_ff;
   logic [15:0] mid_port_ff;
   logic [31:0] out_ip_ff;
   logic [15:0] out_port_ff;
   logic [15:0] in_len_ff;
   logic [15:0] out_len_ff;
   logic [63:0] pattern_ff;
   logic [3:0]  pattern_len_ff;
   logic [3:0]  eff_plen;
   logic        wr_en;
   pmlp_pkg::reg_index_type reg_sel;

   logic        advance;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff, in_end_ff, in_trunc_ff;
   logic [TIME_WIDTH-1:0] in_time_ff;

   logic                  sum_valid;
   pmlp_pkg::summary_type sum;
   pmlp_pkg::result_type  result;
   logic                  rsp_valid_ff;
   pmlp_pkg::result_type  rsp_ff;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = pmlp_pkg::reg_index_type'(paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ip_ff      <= 32'd2899970572;
         mid_port_ff    <= 16'd60050;
         out_ip_ff      <= 32'd706216475;
         out_port_ff    <= 16'd0;
         in_len_ff      <= 16'd0;
         out_len_ff     <= 16'd0;
         pattern_ff     <= 64'd80565822370098;
         pattern_len_ff <= 4'd6;
      end else if (wr_en) begin
         case (reg_sel)
            pmlp_pkg::REG_MID_IP:      mid_ip_ff      <= pwdata[31:0];
            pmlp_pkg::REG_MID_PORT:    mid_port_ff    <= pwdata[15:0];
            pmlp_pkg::REG_OUT_IP:      out_ip_ff      <= pwdata[31:0];
            pmlp_pkg::REG_OUT_PORT:    out_port_ff    <= pwdata[15:0];
            pmlp_pkg::REG_IN_LEN:      in_len_ff      <= pwdata[15:0];
            pmlp_pkg::REG_OUT_LEN:     out_len_ff     <= pwdata[15:0];
            pmlp_pkg::REG_PATTERN:     pattern_ff     <= pwdata;
            pmlp_pkg::REG_PATTERN_LEN: pattern_len_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pmlp_pkg::REG_MID_IP:      prdata = {32'd0, mid_ip_ff};
         pmlp_pkg::REG_MID_PORT:    prdata = {48'd0, mid_port_ff};
         pmlp_pkg::REG_OUT_IP:      prdata = {32'd0, out_ip_ff};
         pmlp_pkg::REG_OUT_PORT:    prdata = {48'd0, out_port_ff};
         pmlp_pkg::REG_IN_LEN:      prdata = {48'd0, in_len_ff};
         pmlp_pkg::REG_OUT_LEN:     prdata = {48'd0, out_len_ff};
         pmlp_pkg::REG_PATTERN:     prdata = pattern_ff;
         pmlp_pkg::REG_PATTERN_LEN: prdata = {60'd0, pattern_len_ff};
         default:                   prdata = '0;
      endcase
   end

   assign eff_plen = (pattern_len_ff > 4'(CLAMP)) ? 4'(CLAMP) : pattern_len_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
         in_end_ff   <= req_frame_end;
         in_trunc_ff <= req_truncated;
         in_time_ff  <= req_timestamp_us[TIME_WIDTH-1:0];
      end
   end

   pmlp_parser #(
      .MAX_PATTERN (MAX_PATTERN),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .byte_valid  (in_valid_ff),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .frame_end   (in_end_ff),
      .truncated   (in_trunc_ff),
      .timestamp   (in_time_ff),
      .eff_plen    (eff_plen),
      .pattern     (pattern_ff),
      .sum_valid   (sum_valid),
      .sum         (sum)
   );

   pmlp_decide #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .sum_valid   (sum_valid),
      .sum         (sum),
      .mid_ip      (mid_ip_ff),
      .mid_port    (mid_port_ff),
      .out_ip      (out_ip_ff),
      .out_port    (pwdata[15:0]),
      .in_len      (in_len_ff),
      .out_len     (out_len_ff),
      .eff_plen    (eff_plen),
      .port_reload (wr_en && reg_sel == pmlp_pkg::REG_OUT_PORT),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sum_valid) rsp_ff <= result;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_class     = rsp_ff.frame_class;
   assign rsp_port_learned    = rsp_ff.port_learned;
   assign rsp_learned_port    = rsp_ff.learned_port;
   assign rsp_latency_valid   = rsp_ff.latency_valid;
   assign rsp_latency_us      = rsp_ff.latency_us;
   assign rsp_in_frame_index  = rsp_ff.in_frame_index;
   assign rsp_out_frame_index = rsp_ff.out_frame_index;

   a_lat_outbound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.latency_valid |-> rsp_ff.frame_class == pmlp_pkg::CLS_OUTBOUND)
      else $error("latency reported on a frame that is not an outbound match");

   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_class == pmlp_pkg::CLS_IGNORED |->
      !rsp_ff.latency_valid && !rsp_ff.port_learned && rsp_ff.in_frame_index == 32'd0)
      else $error("ignored frame carries match results");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      advance && !sum_valid |=> !rsp_valid_ff)
      else $error("response raised without a parsed frame");

endmodule

[sim/tb_packet_match_latency_probe.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_match_latency_probe
// Builds Ethernet/IPv4 UDP and TCP frames, clean and damaged, feeds them to the
// probe a byte per request and checks every per-frame result against a
// cycle-free model of the parser, matcher and latency pairing.
// ----------------------------------------------------------------------------
module tb_packet_match_latency_probe;
   import pmlp_pkg::*;

   localparam int FL_NONE    = 0;
   localparam int FL_TRUNC   = 1;
   localparam int FL_ETYPE   = 2;
   localparam int FL_VER     = 3;
   localparam int FL_IHL     = 4;
   localparam int FL_PROTO   = 5;
   localparam int FL_DOFF    = 6;
   localparam int FL_LEN     = 7;
   localparam int FL_CUT     = 8;
   localparam int FL_RESTART = 9;
   localparam int FL_PAD     = 10;
   localparam int FL_LAST    = 10;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_BYTES = 230;

   typedef struct {
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [63:0] ts;
      logic        trunc;
   } frame_byte_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_frame_start = 1'b0;
   logic        req_frame_end = 1'b0;
   logic [63:0] req_timestamp_us = '0;
   logic        req_truncated = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_class;
   logic        rsp_port_learned;
   logic [15:0] rsp_learned_port;
   logic        rsp_latency_valid;
   logic [63:0] rsp_latency_us;
   logic [31:0] rsp_in_frame_index;
   logic [31:0] rsp_out_frame_index;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic        pready;

   packet_match_latency_probe dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // register copies
   logic [31:0] cfg_mid_ip, cfg_out_ip;
   logic [15:0] cfg_mid_port, cfg_out_port, cfg_in_len, cfg_out_len;
   logic [63:0] cfg_pattern;
   logic [3:0]  cfg_pattern_len;

   // parser and pairing state
   logic [31:0] frame_count;
   logic [15:0] byte_ofs;
   logic [63:0] frame_ts;
   logic [63:0] hdr [2];
   logic [15:0] pay_left, pay_total;
   logic [63:0] window;
   logic        found, inbound_seen, port_known, in_frame, frame_bad, pay_started;
   logic [15:0] out_port_used;
   logic        pending_v;
   logic [63:0] pending_ts;
   logic [31:0] pending_idx;

   frame_byte_t byte_q[$];
   result_type  expected_q[$];

   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   logic hold_go = 1'b0;
   int hold_left = 0;
   int mismatches = 0;
   int n_results = 0;
   int n_class [4] = '{0, 0, 0, 0};
   int n_latency = 0;
   logic [63:0] ts_clock = 64'd1000;

   function automatic int pat_bytes();
      return (cfg_pattern_len > 4'd8) ? 8 : int'(cfg_pattern_len);
   endfunction

   function automatic void reload_out_port();
      out_port_used = cfg_out_port;
      port_known = cfg_out_port != 0;
      inbound_seen = cfg_out_port != 0;
   endfunction

   function automatic void model_reset();
      cfg_mid_ip = 32'd2899970572;
      cfg_mid_port = 16'd60050;
      cfg_out_ip = 32'd706216475;
      cfg_out_port = 16'd0;
      cfg_in_len = 16'd0;
      cfg_out_len = 16'd0;
      cfg_pattern = 64'd80565822370098;
      cfg_pattern_len = 4'd6;
      frame_count = '0;
      byte_ofs = '0;
      frame_ts = '0;
      hdr[0] = '0;
      hdr[1] = '0;
      pay_left = '0;
      pay_total = '0;
      window = '0;
      found = 1'b0;
      pending_v = 1'b0;
      pending_ts = '0;
      pending_idx = '0;
      in_frame = 1'b0;
      frame_bad = 1'b0;
      pay_started = 1'b0;
      reload_out_port();
   endfunction

   function automatic void apply_reg(reg_index_type idx, logic [63:0] v);
      case (idx)
         REG_MID_IP: cfg_mid_ip = v[31:0];
         REG_MID_PORT: cfg_mid_port = v[15:0];
         REG_OUT_IP: cfg_out_ip = v[31:0];
         REG_OUT_PORT: begin
            cfg_out_port = v[15:0];
            reload_out_port();
         end
         REG_IN_LEN: cfg_in_len = v[15:0];
         REG_OUT_LEN: cfg_out_len = v[15:0];
         REG_PATTERN: cfg_pattern = v;
         REG_PATTERN_LEN: cfg_pattern_len = v[3:0];
         default: ;
      endcase
   endfunction

   function automatic void parse_header_byte(logic [7:0] b);
      int o, ihl, l4, doff, pstart, p, seen, plen;
      logic [15:0] etype;
      logic [7:0] vi, proto;
      logic [63:0] m;
      bit have;
      o = byte_ofs;
      if (o == 12) hdr[1][23:16] = b;
      if (o == 13) hdr[1][15:8] = b;
      if (o == 14) hdr[1][39:32] = b;
      if (o == 16) hdr[0][15:8] = b;
      if (o == 17) hdr[0][7:0] = b;
      if (o == 23) hdr[1][47:40] = b;
      if (o >= 30 && o <= 33) hdr[0][32 + 8 * (33 - o) +: 8] = b;
      etype = hdr[1][23:8];
      vi = hdr[1][39:32];
      proto = hdr[1][47:40];
      if (o == 14 && (etype != ETYPE_IPV4 || vi[7:4] != 4'd4 || vi[3:0] < 4'd5)) begin
         frame_bad = 1'b1;
         return;
      end
      if (o == 23 && proto != PROTO_TCP && proto != PROTO_UDP) begin
         frame_bad = 1'b1;
         return;
      end
      if (o <= 14) return;
      ihl = vi[3:0];
      l4 = 14 + 4 * ihl;
      if (o == l4 + 2) hdr[0][31:24] = b;
      if (o == l4 + 3) hdr[0][23:16] = b;
      if (o == l4 + 4) hdr[1][63:56] = b;
      if (o == l4 + 5) hdr[1][55:48] = b;
      if (o == l4 + 12) hdr[1][31:24] = b;
      if (!pay_started) begin
         have = 0;
         pstart = 0;
         plen = 0;
         if (proto == PROTO_UDP) begin
            have = 1;
            pstart = l4 + 8;
            plen = int'(hdr[1][63:48]) - 8;
         end else if (o > l4 + 12) begin
            doff = hdr[1][31:28];
            if (doff < 5) begin
               frame_bad = 1'b1;
               return;
            end
            have = 1;
            pstart = l4 + 4 * doff;
            plen = int'(hdr[0][15:0]) - 4 * (ihl + doff);
         end
         if (have && o == pstart) begin
            if (plen <= 0) begin
               frame_bad = 1'b1;
               return;
            end
            pay_started = 1'b1;
            pay_total = plen[15:0];
            pay_left = plen[15:0];
         end
      end
      if (pay_started && pay_left > 0) begin
         p = pat_bytes();
         window = {window[55:0], b};
         pay_left = pay_left - 1'b1;
         seen = pay_total - pay_left;
         if (p > 0 && seen >= p) begin
            m = {64{1'b1}} >> (64 - 8 * p);
            if (((window ^ cfg_pattern) & m) == 0) found = 1'b1;
         end
      end
   endfunction

   // one request in; returns 1 with the frame result when a frame closes
   function automatic bit classify_frame_byte(frame_byte_t it, output result_type r);
      logic [31:0] dip;
      logic [15:0] dport;
      bit c, out_ok, in_ok;
      r = '0;
      if (it.first) begin
         frame_count = frame_count + 1'b1;
         in_frame = 1'b1;
         frame_bad = 1'b0;
         pay_started = 1'b0;
         byte_ofs = '0;
         frame_ts = it.ts;
         hdr[0] = '0;
         hdr[1] = '0;
         pay_left = '0;
         pay_total = '0;
         window = '0;
         found = 1'b0;
      end
      if (!in_frame) return 0;
      if (it.trunc) frame_bad = 1'b1;
      if (!frame_bad) parse_header_byte(it.data);
      if (byte_ofs != 16'hFFFF) byte_ofs = byte_ofs + 1'b1;
      if (!it.last) return 0;
      in_frame = 1'b0;
      r.frame_class = CLS_IGNORED;
      if (!frame_bad && pay_started && pay_left == 0) begin
         dip = hdr[0][63:32];
         dport = hdr[0][31:16];
         c = pat_bytes() == 0 || found;
         out_ok = cfg_out_len == 0 || cfg_out_len == pay_total;
         in_ok = cfg_in_len == 0 || cfg_in_len == pay_total;
         if (inbound_seen && !port_known && out_ok && dip == cfg_out_ip && c) begin
            out_port_used = dport;
            port_known = 1'b1;
            r.port_learned = 1'b1;
         end
         if (dip == cfg_mid_ip && dport == cfg_mid_port && in_ok && c) begin
            r.frame_class = CLS_INBOUND;
            pending_v = 1'b1;
            pending_ts = frame_ts;
            pending_idx = frame_count;
            if (!inbound_seen && !port_known) inbound_seen = 1'b1;
         end else if (port_known && dip == cfg_out_ip && dport == out_port_used
                      && out_ok && c) begin
            r.frame_class = CLS_OUTBOUND;
            if (pending_v) begin
               r.latency_valid = 1'b1;
               r.latency_us = frame_ts - pending_ts;
               r.in_frame_index = pending_idx;
               pending_v = 1'b0;
            end
         end else begin
            r.frame_class = CLS_PARSED;
         end
      end
      r.learned_port = port_known ? out_port_used : 16'd0;
      r.out_frame_index = frame_count;
      return 1;
   endfunction

   // request driver, predicting each accepted byte
   always @(posedge clock) begin
      frame_byte_t nxt, cur;
      result_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur.data = req_data_byte;
            cur.first = req_frame_start;
            cur.last = req_frame_end;
            cur.ts = req_timestamp_us;
            cur.trunc = req_truncated;
            if (classify_frame_byte(cur, r)) expected_q.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               nxt = byte_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= nxt.data;
               req_frame_start <= nxt.first;
               req_frame_end <= nxt.last;
               req_timestamp_us <= nxt.ts;
               req_truncated <= nxt.trunc;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= 500;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_go && hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
      end
   end

   // result monitor
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: class %0d frame %0d", rsp_frame_class,
                        rsp_out_frame_index);
         end else begin
            e = expected_q.pop_front();
            n_class[e.frame_class]++;
            if (e.latency_valid) n_latency++;
            if (rsp_frame_class !== e.frame_class || rsp_port_learned !== e.port_learned
                || rsp_learned_port !== e.learned_port
                || rsp_latency_valid !== e.latency_valid
                || rsp_latency_us !== e.latency_us
                || rsp_in_frame_index !== e.in_frame_index
                || rsp_out_frame_index !== e.out_frame_index) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch frame %0d: exp cls %0d lrn %0b port %0d lv %0b lat %0d in %0d",
                           e.out_frame_index, e.frame_class, e.port_learned, e.learned_port,
                           e.latency_valid, e.latency_us, e.in_frame_index);
                  $display("   got frame %0d: cls %0d lrn %0b port %0d lv %0b lat %0d in %0d",
                           rsp_out_frame_index, rsp_frame_class, rsp_port_learned,
                           rsp_learned_port, rsp_latency_valid, rsp_latency_us,
                           rsp_in_frame_index);
               end
            end
         end
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [63:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      apply_reg(idx, v);
   endtask

   task automatic push_stray(input int n, input bit close);
      frame_byte_t it;
      for (int i = 0; i < n; i++) begin
         it.data = $urandom;
         it.first = 1'b0;
         it.last = close && i == n - 1;
         it.ts = {$urandom, $urandom};
         it.trunc = $urandom_range(1);
         byte_q.push_back(it);
      end
   endtask

   task automatic gen_frame(input logic [31:0] dip, input logic [15:0] dport, input bit tcp,
                            input int plen, input bit with_pat, input bit at_end,
                            input int flaw);
      logic [7:0] fb[$];
      logic [15:0] tot, ulen;
      logic [7:0] proto, vi;
      int ihl, doff, p, pos, n, tpos;
      frame_byte_t it;
      ihl = ($urandom_range(9) == 0) ? $urandom_range(6, 15) : 5;
      doff = (tcp && $urandom_range(5) == 0) ? $urandom_range(6, 15) : 5;
      if (flaw == FL_IHL) ihl = $urandom_range(0, 4);
      if (flaw == FL_DOFF) doff = $urandom_range(0, 4);
      for (int i = 0; i < 12; i++) fb.push_back($urandom);
      if (flaw == FL_ETYPE) begin
         tot = $urandom;
         if (tot == ETYPE_IPV4) tot = 16'h86DD;
      end else begin
         tot = ETYPE_IPV4;
      end
      fb.push_back(tot[15:8]);
      fb.push_back(tot[7:0]);
      vi = {4'd4, 4'(ihl)};
      if (flaw == FL_VER) vi[7:4] = $urandom_range(1) ? 4'd6 : 4'($urandom_range(0, 3));
      fb.push_back(vi);
      fb.push_back($urandom);
      tot = 4 * ihl + (tcp ? 4 * doff : 8) + plen;
      if (flaw == FL_LEN && tcp) tot = 4 * (ihl + doff) - $urandom_range(0, 20);
      fb.push_back(tot[15:8]);
      fb.push_back(tot[7:0]);
      for (int i = 0; i < 5; i++) fb.push_back($urandom);
      proto = tcp ? PROTO_TCP : PROTO_UDP;
      if (flaw == FL_PROTO) begin
         proto = $urandom;
         if (proto == PROTO_TCP || proto == PROTO_UDP) proto = 8'd1;
      end
      fb.push_back(proto);
      for (int i = 0; i < 6; i++) fb.push_back($urandom);
      fb.push_back(dip[31:24]);
      fb.push_back(dip[23:16]);
      fb.push_back(dip[15:8]);
      fb.push_back(dip[7:0]);
      for (int i = 5; i < ihl; i++) for (int k = 0; k < 4; k++) fb.push_back($urandom);
      fb.push_back($urandom);
      fb.push_back($urandom);
      fb.push_back(dport[15:8]);
      fb.push_back(dport[7:0]);
      if (tcp) begin
         for (int i = 0; i < 8; i++) fb.push_back($urandom);
         fb.push_back({4'(doff), 4'($urandom)});
         for (int i = 0; i < 7; i++) fb.push_back($urandom);
         for (int i = 5; i < doff; i++) for (int k = 0; k < 4; k++) fb.push_back($urandom);
      end else begin
         ulen = (flaw == FL_LEN) ? 16'($urandom_range(0, 8)) : 16'(8 + plen);
         fb.push_back(ulen[15:8]);
         fb.push_back(ulen[7:0]);
         fb.push_back($urandom);
         fb.push_back($urandom);
      end
      n = fb.size();
      if (flaw != FL_LEN) for (int i = 0; i < plen; i++) fb.push_back($urandom);
      p = pat_bytes();
      if (with_pat && p > 0 && plen > 0 && flaw != FL_LEN) begin
         pos = (plen > p) ? (at_end ? plen - p : $urandom_range(0, plen - p)) : 0;
         for (int k = 0; k < p && pos + k < plen; k++)
            fb[n + pos + k] = cfg_pattern[8 * (p - 1 - k) +: 8];
      end
      if (flaw == FL_PAD) repeat ($urandom_range(1, 20)) fb.push_back($urandom);
      if (flaw == FL_CUT) n = $urandom_range(1, fb.size() - 1);
      else n = fb.size();
      ts_clock = ts_clock + $urandom_range(1, 5000);
      if ($urandom_range(19) == 0) ts_clock = {$urandom, $urandom};
      if (flaw == FL_RESTART) begin
         tpos = $urandom_range(1, n - 1);
         for (int i = 0; i < tpos; i++) begin
            it.data = fb[i];
            it.first = i == 0;
            it.last = 1'b0;
            it.ts = {$urandom, $urandom};
            it.trunc = 1'b0;
            byte_q.push_back(it);
         end
      end
      tpos = (flaw == FL_TRUNC) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
         it.data = fb[i];
         it.first = i == 0;
         it.last = i == n - 1;
         it.ts = (i == 0) ? ts_clock : {$urandom, $urandom};
         it.trunc = i == tpos;
         byte_q.push_back(it);
      end
   endtask

   task automatic gen_random_frame(input logic [15:0] learn_port);
      int r, plen;
      logic [31:0] dip;
      logic [15:0] dport;
      r = $urandom_range(99);
      plen = ($urandom_range(19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      if (r < 35) begin
         dip = cfg_mid_ip;
         dport = cfg_mid_port;
         if (cfg_in_len != 0 && $urandom_range(4) != 0) plen = cfg_in_len;
      end else if (r < 65) begin
         dip = cfg_out_ip;
         dport = (cfg_out_port != 0) ? cfg_out_port : learn_port;
         if ($urandom_range(9) == 0) dport = $urandom;
         if (cfg_out_len != 0 && $urandom_range(4) != 0) plen = cfg_out_len;
      end else begin
         dip = $urandom;
         dport = $urandom;
      end
      if (plen > 300) plen = $urandom_range(1, 24);
      gen_frame(dip, dport, $urandom_range(1), plen, $urandom_range(9) != 0,
                $urandom_range(3) == 0, (r >= 80) ? $urandom_range(1, FL_LAST) : FL_NONE);
      if ($urandom_range(24) == 0) push_stray($urandom_range(1, 4), $urandom_range(1));
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (byte_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_phase_regs(input int ph);
      case (ph)
         1: begin
            csr_write(REG_MID_IP, $urandom);
            csr_write(REG_MID_PORT, $urandom);
            csr_write(REG_OUT_IP, $urandom);
            csr_write(REG_OUT_PORT, 64'd0);
            csr_write(REG_IN_LEN, 64'd0);
            csr_write(REG_OUT_LEN, 64'd0);
            csr_write(REG_PATTERN, {$urandom, $urandom});
            csr_write(REG_PATTERN_LEN, 64'd8);
         end
         2: begin
            csr_write(REG_PATTERN_LEN, 64'd0);
            csr_write(REG_OUT_PORT, 64'hFFFF);
            csr_write(REG_MID_PORT, 64'd0);
            csr_write(REG_MID_IP, 64'd0);
            csr_write(REG_OUT_IP, 64'hFFFF_FFFF);
         end
         3: begin
            csr_write(REG_PATTERN, {64{1'b1}});
            csr_write(REG_PATTERN_LEN, 64'd15);
            csr_write(REG_IN_LEN, 64'd12);
            csr_write(REG_OUT_LEN, 64'd16);
            csr_write(REG_OUT_PORT, 64'd0);
         end
         4: begin
            csr_write(REG_PATTERN, 64'd0);
            csr_write(REG_PATTERN_LEN, 64'd1);
            csr_write(REG_IN_LEN, 64'd0);
            csr_write(REG_OUT_LEN, 64'd0);
            csr_write(REG_MID_IP, 64'hFFFF_FFFF);
            csr_write(REG_MID_PORT, 64'hFFFF);
            csr_write(REG_OUT_IP, 64'd0);
         end
         5: begin
            csr_write(REG_IN_LEN, 64'hFFFF);
            csr_write(REG_OUT_LEN, 64'hFFFF);
            csr_write(REG_PATTERN_LEN, 64'd3);
            csr_write(REG_OUT_PORT, $urandom_range(1, 65535));
         end
         6: begin
            csr_write(REG_MID_IP, $urandom);
            csr_write(REG_MID_PORT, $urandom);
            csr_write(REG_OUT_IP, $urandom);
            csr_write(REG_IN_LEN, $urandom_range(0, 1) ? 64'd0 : 64'd8);
            csr_write(REG_OUT_LEN, 64'd0);
            csr_write(REG_PATTERN, {$urandom, $urandom});
            csr_write(REG_PATTERN_LEN, $urandom_range(0, 15));
            csr_write(REG_OUT_PORT, 64'd0);
         end
         7: begin
            csr_write(REG_IN_LEN, 64'd0);
            csr_write(REG_PATTERN_LEN, 64'd4);
            csr_write(REG_OUT_PORT, 64'd0);
         end
         default: ;
      endcase
   endtask

   initial begin
      int nbytes, nframes;
      logic [15:0] learn_port;
      model_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray bytes, each damage kind, pattern at the final position
      push_stray(3, 1'b1);
      for (int f = FL_NONE; f <= FL_LAST; f++)
         gen_frame(cfg_mid_ip, cfg_mid_port, f == FL_DOFF || f[0], 10, 1'b1, 1'b0, f);
      gen_frame(cfg_out_ip, 16'd4242, 1'b0, 9, 1'b1, 1'b1, FL_NONE);
      gen_frame(cfg_mid_ip, cfg_mid_port, 1'b1, 6, 1'b1, 1'b1, FL_NONE);
      gen_frame(cfg_out_ip, 16'd4242, 1'b1, 20, 1'b1, 1'b1, FL_NONE);
      gen_frame(cfg_out_ip, 16'd4242, 1'b0, 20, 1'b0, 1'b0, FL_NONE);
      wait_drained();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_phase_regs(ph);
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
            default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
         endcase
         learn_port = $urandom;
         nbytes = byte_q.size();
         nframes = 0;
         while (byte_q.size() - nbytes < PHASE_BYTES || nframes < 8) begin
            gen_random_frame(learn_port);
            nframes++;
         end
         if (ph == 4) begin
            @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         wait_drained();
      end

      $display("covered %0d frames: ignored %0d, parsed %0d, inbound %0d, outbound %0d",
               n_results, n_class[0], n_class[1], n_class[2], n_class[3]);
      $display("latency pairs closed %0d across %0d register settings", n_latency,
               NUM_PHASES);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
